// File: hdl/cdeq_pkg.sv
// Package for the circular double-ended queue.
// Holds the beat structs, opcode and status codes, controller states and the default depth.
// No dependencies.
`default_nettype none

package cdeq_pkg;

  // Default number of entries in the element store.
  localparam int DEFAULT_DEPTH = 8;

  // Operation carried by an input beat.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } opcode_e;

  // Completion status carried by an output beat.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [31:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    status_e            status;
    logic [3:0]         count;
  } out_beat_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the input beat
    logic exec;  // perform the operation on the store and pointers
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: hdl/cdeq_ctrl.sv
// Controller state machine for the circular double-ended queue.
// Sequences accept, execute and respond; depends on cdeq_pkg.
`default_nettype none

module cdeq_ctrl
  import cdeq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    out_stall_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/cdeq_dpath.sv
// Datapath for the circular double-ended queue: element memory, head and tail
// pointers, element count and the result register. Depends on cdeq_pkg.
`default_nettype none

module cdeq_dpath
  import cdeq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire dp_cmd_t  cmd_i,
  input  wire in_beat_t in_beat_i,
  output out_beat_t     out_beat_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Captured input beat.
  opcode_e            op_q;
  logic signed [31:0] val_q;

  // Queue control state.
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  // Result state.
  status_e     status_q, status_d;
  logic        pop_ok_q, pop_ok_d;
  logic [31:0] rdata_q;

  // Memory access controls.
  logic          wr_en, rd_en;
  logic [PW-1:0] wr_addr, rd_addr;

  logic [31:0] mem [DEPTH];

  logic          is_push, is_front, full, empty;
  logic [PW-1:0] head_dec, head_inc, tail_dec, tail_inc;
  logic [CW+3:0] count_ext;

  // Capture the input beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_beat_i.opcode;
      val_q <= in_beat_i.push_value;
    end
  end

  // Pointer neighbors with wrap at the store boundary.
  assign head_dec = (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);
  assign head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign tail_dec = (tail_q == '0) ? PW'(DEPTH - 1) : tail_q - PW'(1);
  assign tail_inc = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);

  assign is_push  = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_REAR);
  assign is_front = (op_q == OP_PUSH_FRONT) || (op_q == OP_POP_FRONT);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);

  // Operation decode and next state.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = '0;
    rd_addr  = is_front ? head_q : tail_q;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      pop_ok_d = 1'b0;
      if (is_push) begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else if (empty) begin
          // First element always lands in entry zero.
          head_d  = '0;
          tail_d  = '0;
          count_d = CW'(1);
          wr_en   = 1'b1;
          wr_addr = '0;
        end else if (is_front) begin
          head_d  = head_dec;
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = head_dec;
        end else begin
          tail_d  = tail_inc;
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = tail_inc;
        end
      end else begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          count_d  = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            // Last element leaves: pointers return home.
            head_d = '0;
            tail_d = '0;
          end else if (is_front) begin
            head_d = head_inc;
          end else begin
            tail_d = tail_dec;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Element memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Result beat; the count field keeps its low four bits.
  assign count_ext            = {4'b0000, count_q};
  assign out_beat_o.pop_value = pop_ok_q ? rdata_q : '0;
  assign out_beat_o.status    = status_q;
  assign out_beat_o.count     = count_ext[3:0];

endmodule

`default_nettype wire

// File: hdl/circular_double_ended_queue.sv
// Circular double-ended queue: push and pop at either end of a DEPTH-entry store.
// Each beat is captured in S_IDLE, the store is accessed in S_EXEC with registered read data,
// and the result beat is valid in S_RESP; no new beat is taken until the result leaves,
// so the input stalls while a result waits.
// Reset: pointers and count clear to zero and the queue is empty; the store is not cleared.
`default_nettype none

module circular_double_ended_queue
  import cdeq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_beat_t in_beat_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_beat_t     out_beat_o
);

  dp_cmd_t cmd;

  // Sequencing of each beat.
  cdeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Store, pointers and result.
  cdeq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_beat_i  (in_beat_i),
    .out_beat_o (out_beat_o)
  );

  // A pending result blocks new input.
  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result beat is pending");

  // A result never appears in the cycle right after an accept.
  a_accept_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result beat too early after accept");

  // Underflow only happens on an empty queue.
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status == ST_UNDERFLOW) |-> (out_beat_o.count == 4'd0))
    else $error("underflow reported with elements held");

  // Failed operations return a zero value.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status != ST_OK) |-> (out_beat_o.pop_value == '0))
    else $error("nonzero value on a failed operation");

endmodule

`default_nettype wire

// File: test/circular_double_ended_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the circular double-ended queue.
// Checks every result beat against a deque predictor kept inside the bench,
// under random valid/stall gaps. Depends on cdeq_pkg and circular_double_ended_queue.

module circular_double_ended_queue_tb;
  import cdeq_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_OPS   = 1600;
  localparam int PHASE_LEN    = 100;
  localparam int HOLD_MARK    = 500;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_COUNT   = 2;
  localparam int DRAIN_CYCLES = 10;
  // About 1625 beats, plus sender gaps, receiver stalls and two long holds,
  // stay far below this.
  localparam int CYCLE_LIMIT  = 250000;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  // Idling pattern in force while a beat is offered.
  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  typedef struct {
    in_beat_t    beat;
    idle_phase_e phase;
  } pending_op_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_beat_t    in_beat_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_beat_t   out_beat_o;

  pending_op_t op_queue[$];
  out_beat_t   awaited_results[$];
  idle_phase_e drive_phase    = PH_FREE;
  int          ops_accepted   = 0;
  int          hold_left      = 0;
  int          holds_done     = 0;
  int          cycle_count    = 0;
  int          mismatch_count = 0;
  int          results_seen   = 0;
  int          overflow_seen  = 0;
  int          underflow_seen = 0;
  int          full_seen      = 0;

  // Predictor state: the deque as the block should hold it.
  logic signed [31:0] deque_store [DEPTH];
  logic [PTR_W-1:0]   deque_head  = '0;
  logic [PTR_W-1:0]   deque_tail  = '0;
  logic               deque_empty = 1'b1;

  circular_double_ended_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int deque_count();
    if (deque_empty) return 0;
    return ((int'(deque_tail) - int'(deque_head) + DEPTH) % DEPTH) + 1;
  endfunction

  // Applies one operation to the predicted deque and returns its result beat.
  function automatic out_beat_t deque_apply(in_beat_t beat);
    out_beat_t res;
    logic [PTR_W-1:0] slot;
    res = '0;
    res.status = ST_OK;
    case (beat.opcode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (deque_count() == DEPTH) begin
          res.status = ST_OVERFLOW;
        end else if (deque_empty) begin
          // The first element always lands in slot zero.
          deque_head = '0;
          deque_tail = '0;
          deque_empty = 1'b0;
          deque_store[0] = beat.push_value;
        end else if (beat.opcode == OP_PUSH_FRONT) begin
          deque_head = (deque_head == '0) ? LAST_SLOT : deque_head - PTR_W'(1);
          deque_store[deque_head] = beat.push_value;
        end else begin
          deque_tail = (deque_tail == LAST_SLOT) ? '0 : deque_tail + PTR_W'(1);
          deque_store[deque_tail] = beat.push_value;
        end
      end
      default: begin
        if (deque_empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          slot = (beat.opcode == OP_POP_FRONT) ? deque_head : deque_tail;
          res.pop_value = deque_store[slot];
          if (deque_head == deque_tail) begin
            // Removing the last element resets both pointers.
            deque_empty = 1'b1;
            deque_head = '0;
            deque_tail = '0;
          end else if (beat.opcode == OP_POP_FRONT) begin
            deque_head = (deque_head == LAST_SLOT) ? '0 : deque_head + PTR_W'(1);
          end else begin
            deque_tail = (deque_tail == '0) ? LAST_SLOT : deque_tail - PTR_W'(1);
          end
        end
      end
    endcase
    res.count = 4'(deque_count());
    return res;
  endfunction

  // Values lean toward the signed extremes now and then.
  function automatic logic [31:0] random_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_op(opcode_e op, logic [31:0] value,
                                   idle_phase_e ph = PH_FREE);
    pending_op_t item;
    item.beat.opcode = op;
    item.beat.push_value = value;
    item.phase = ph;
    op_queue.push_back(item);
  endfunction

  // Driver: offers queued beats, predicts each one when it is accepted.
  always @(posedge clk_i) begin : driver
    logic        next_valid;
    pending_op_t next_op;
    int          idle_pct;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(deque_apply(in_beat_i));
        ops_accepted <= ops_accepted + 1;
        next_valid = 1'b0;
      end
      if (!next_valid && op_queue.size() > 0) begin
        case (op_queue[0].phase)
          PH_SEND_IDLE: idle_pct = 59;
          PH_BOTH:      idle_pct = 20;
          default:      idle_pct = 0;
        endcase
        if ($urandom_range(99) >= idle_pct) begin
          next_op = op_queue.pop_front();
          in_beat_i <= next_op.beat;
          drive_phase <= next_op.phase;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Monitor: compares each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    int        stall_pct;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with none expected, got %p", $time, out_beat_o);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          results_seen++;
          if (want.status == ST_OVERFLOW) overflow_seen++;
          if (want.status == ST_UNDERFLOW) underflow_seen++;
          if (want.count == 4'(DEPTH)) full_seen++;
          if (out_beat_o.pop_value !== want.pop_value) begin
            $display("%0t: pop_value expected %0d, got %0d", $time,
                     $signed(want.pop_value), $signed(out_beat_o.pop_value));
            mismatch_count++;
          end
          if (out_beat_o.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time,
                     want.status, out_beat_o.status);
            mismatch_count++;
          end
          if (out_beat_o.count !== want.count) begin
            $display("%0t: count expected %0d, got %0d", $time,
                     want.count, out_beat_o.count);
            mismatch_count++;
          end
        end
      end
      case (drive_phase)
        PH_RECV_STALL: stall_pct = 59;
        PH_BOTH:       stall_pct = 20;
        default:       stall_pct = 0;
      endcase
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Long receiver hold-offs that keep a result waiting so the block stalls its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < HOLD_COUNT && ops_accepted >= HOLD_MARK * (holds_done + 1)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, awaited_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          seg_left;
    int          push_pct;
    idle_phase_e ph;
    opcode_e     op;

    // Directed: underflow at both ends, push into empty, pop of the last
    // element, head wrap, fill to full, overflow at both ends, drain.
    queue_op(OP_POP_FRONT, random_value());
    queue_op(OP_POP_REAR, random_value());
    queue_op(OP_PUSH_FRONT, 32'h7fff_ffff);
    queue_op(OP_POP_REAR, random_value());
    queue_op(OP_PUSH_REAR, 32'h8000_0000);
    queue_op(OP_PUSH_FRONT, 32'h0000_0000);
    queue_op(OP_PUSH_FRONT, 32'hffff_ffff);
    queue_op(OP_PUSH_REAR, 32'h5555_5555);
    queue_op(OP_PUSH_REAR, 32'haaaa_aaaa);
    queue_op(OP_PUSH_FRONT, 32'h0000_0001);
    queue_op(OP_PUSH_REAR, 32'h0f0f_0f0f);
    queue_op(OP_PUSH_FRONT, 32'hf0f0_f0f0);
    queue_op(OP_PUSH_FRONT, random_value());
    queue_op(OP_PUSH_REAR, random_value());
    for (int k = 0; k < DEPTH; k++) begin
      queue_op(k[0] ? OP_POP_REAR : OP_POP_FRONT, random_value());
    end
    queue_op(OP_POP_FRONT, random_value());

    // Random: bursts biased toward pushes, toward pops or even, so the queue keeps
    // swinging between empty and full; idling pattern rotates per block.
    seg_left = 0;
    push_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 24);
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      seg_left--;
      ph = idle_phase_e'((n / PHASE_LEN) % 4);
      if ($urandom_range(99) < push_pct) begin
        op = ($urandom_range(1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else begin
        op = ($urandom_range(1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
      end
      queue_op(op, random_value(), ph);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to go in and every result to come back.
    do @(posedge clk_i);
    while (op_queue.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result beats: %0d overflows, %0d underflows, %0d at full depth.",
             results_seen, overflow_seen, underflow_seen, full_seen);
    $display("Ran %0d long receiver hold-offs across four idling patterns.", holds_done);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
